/* rtl/dlle_pkg.sv */
// Shared constants, codes and types of the doubly linked list engine.
package dlle_pkg;

   localparam int NODES       = 32;
   localparam int IDX_W       = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int CNT_W       = $clog2(NODES + 1);
   localparam int MAX_RESULTS = 32;

   localparam logic [3:0] MODE_APPEND    = 4'd0;
   localparam logic [3:0] MODE_INS_HEAD  = 4'd1;
   localparam logic [3:0] MODE_INS_TAIL  = 4'd2;
   localparam logic [3:0] MODE_INS_AFTER = 4'd3;
   localparam logic [3:0] MODE_DEL_HEAD  = 4'd4;
   localparam logic [3:0] MODE_DEL_TAIL  = 4'd5;
   localparam logic [3:0] MODE_DEL_AFTER = 4'd6;
   localparam logic [3:0] MODE_DEL_VALUE = 4'd7;
   localparam logic [3:0] MODE_READ_FWD  = 4'd8;
   localparam logic [3:0] MODE_READ_REV  = 4'd9;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_EMPTY    = 2'd1;
   localparam logic [1:0] STAT_NOTFOUND = 2'd2;
   localparam logic [1:0] STAT_FULL     = 2'd3;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_DECODE = 9'b000000010,
      ST_FETCH  = 9'b000000100,
      ST_SCHK   = 9'b000001000,
      ST_INS_A  = 9'b000010000,
      ST_INS_B  = 9'b000100000,
      ST_DEL    = 9'b001000000,
      ST_RESP   = 9'b010000000,
      ST_RDOUT  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic             pop;
      logic             push;
      logic [IDX_W-1:0] push_idx;
   } alloc_req_type;

endpackage

/* rtl/dlle_alloc.sv */
// Node allocator: fresh-node counter plus a stack of released nodes.
module dlle_alloc (
   input  logic                        clock,
   input  logic                        reset,
   input  dlle_pkg::alloc_req_type     req,
   output logic [dlle_pkg::IDX_W-1:0]  new_node
);

   logic [dlle_pkg::CNT_W-1:0] fresh_ff, fresh_in;
   logic [dlle_pkg::CNT_W-1:0] sp_ff, sp_in;
   logic [dlle_pkg::CNT_W-1:0] sp_dec;
   logic [dlle_pkg::IDX_W-1:0] top_ff;
   logic [dlle_pkg::IDX_W-1:0] free_mem [dlle_pkg::NODES];
   logic                       fresh_left;

   assign fresh_left = fresh_ff < dlle_pkg::CNT_W'(dlle_pkg::NODES);
   assign sp_dec     = sp_ff - 1'b1;
   assign new_node   = fresh_left ? fresh_ff[dlle_pkg::IDX_W-1:0] : top_ff;

   always_comb begin
      fresh_in = fresh_ff;
      sp_in    = sp_ff;
      if (req.pop) begin
         if (fresh_left) fresh_in = fresh_ff + 1'b1;
         else sp_in = sp_dec;
      end else if (req.push) begin
         sp_in = sp_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= '0;
         sp_ff    <= '0;
      end else begin
         fresh_ff <= fresh_in;
         sp_ff    <= sp_in;
      end
   end

   // stack memory: one write, one registered read at the top
   always_ff @(posedge clock) begin
      if (req.push) free_mem[sp_ff[dlle_pkg::IDX_W-1:0]] <= req.push_idx;
      top_ff <= free_mem[sp_dec[dlle_pkg::IDX_W-1:0]];
   end

endmodule

/* rtl/doubly_linked_list_engine.sv */
// Doubly linked list engine: sequencer around value and link memories.
// Flow: IDLE, DECODE, RESP; inserts at head/tail and append finish their work in DECODE;
//   head/tail deletes add FETCH and DEL; key searches add FETCH, a walk in SCHK, then INS_A/INS_B or DEL.
// Reads give the first element in RDOUT after FETCH, then one per cycle while the receiver
//   takes them, set by the link memory read loop; one command at a time.
// Reset (synchronous): list empty, all nodes free, no result pending.
module doubly_linked_list_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [3:0]                  req_mode,
   input  logic signed [31:0]          req_value,
   input  logic signed [31:0]          req_key,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic signed [31:0]          rsp_value_out,
   output logic [5:0]                  rsp_count,
   output logic                        rsp_last
);

   localparam int IW = dlle_pkg::IDX_W;
   localparam int CW = dlle_pkg::CNT_W;

   dlle_pkg::state_type state_ff, state_in;

   // captured command
   logic [3:0]  mode_ff, mode_in;
   logic [31:0] value_ff, value_in;
   logic [31:0] key_ff, key_in;

   // list registers
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in;

   // walk registers
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] n_ff, n_in;
   logic [IW-1:0] q_ff, q_in;
   logic          wastail_ff, wastail_in;
   logic [CW-1:0] k_ff, k_in;
   logic [1:0]    status_ff, status_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [5:0]    rsp_count_ff, rsp_count_in;
   logic          rsp_last_ff, rsp_last_in;

   // memories, read together at one address, data registered
   logic [31:0]   val_mem  [dlle_pkg::NODES];
   logic [IW-1:0] next_mem [dlle_pkg::NODES];
   logic [IW-1:0] prev_mem [dlle_pkg::NODES];
   logic [31:0]   rv_ff;
   logic [IW-1:0] rn_ff, rp_ff;
   logic [IW-1:0] raddr;

   logic          val_we, next_we, prev_we;
   logic [IW-1:0] val_wa, next_wa, prev_wa;
   logic [31:0]   val_wd;
   logic [IW-1:0] next_wd, prev_wd;

   dlle_pkg::alloc_req_type alloc_req;
   logic [IW-1:0]           new_node;

   logic          full, empty, slot_free, match, rd_last;
   logic [CW-1:0] total;
   logic [IW-1:0] link;

   dlle_alloc u_alloc (
      .clock    (clock),
      .reset    (reset),
      .req      (alloc_req),
      .new_node (new_node)
   );

   assign full      = count_ff == CW'(dlle_pkg::NODES);
   assign empty     = count_ff == '0;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign total     = (int'(count_ff) < dlle_pkg::MAX_RESULTS) ? count_ff
                                                               : CW'(dlle_pkg::MAX_RESULTS);
   assign rd_last   = k_ff == total - 1'b1;
   assign link      = (mode_ff == dlle_pkg::MODE_READ_FWD) ? rn_ff : rp_ff;
   // delete after skips a match on the tail: it has no successor
   assign match     = (rv_ff == key_ff) &&
                      !((mode_ff == dlle_pkg::MODE_DEL_AFTER) && (cur_ff == tail_ff));

   assign req_ready     = state_ff == dlle_pkg::ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      value_in      = value_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      q_in          = q_ff;
      wastail_in    = wastail_ff;
      k_in          = k_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      raddr         = cur_ff;
      val_we  = 1'b0; val_wa  = '0; val_wd  = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
      alloc_req = '0;

      case (state_ff)
         dlle_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               value_in  = req_value;
               key_in    = req_key;
               status_in = dlle_pkg::STAT_OK;
               state_in  = dlle_pkg::ST_DECODE;
            end
         end

         dlle_pkg::ST_DECODE: begin
            state_in = dlle_pkg::ST_RESP;
            case (mode_ff)
               dlle_pkg::MODE_APPEND, dlle_pkg::MODE_INS_TAIL: begin
                  if (empty && mode_ff == dlle_pkg::MODE_INS_TAIL) begin
                     status_in = dlle_pkg::STAT_EMPTY;
                  end else if (full) begin
                     status_in = dlle_pkg::STAT_FULL;
                  end else begin
                     alloc_req.pop = 1'b1;
                     val_we = 1'b1; val_wa = new_node; val_wd = value_ff;
                     if (empty) begin
                        head_in = new_node;
                     end else begin
                        next_we = 1'b1; next_wa = tail_ff;  next_wd = new_node;
                        prev_we = 1'b1; prev_wa = new_node; prev_wd = tail_ff;
                     end
                     tail_in  = new_node;
                     count_in = count_ff + 1'b1;
                  end
               end
               dlle_pkg::MODE_INS_HEAD: begin
                  if (empty) status_in = dlle_pkg::STAT_EMPTY;
                  else if (full) status_in = dlle_pkg::STAT_FULL;
                  else begin
                     alloc_req.pop = 1'b1;
                     val_we  = 1'b1; val_wa  = new_node; val_wd  = value_ff;
                     next_we = 1'b1; next_wa = new_node; next_wd = head_ff;
                     prev_we = 1'b1; prev_wa = head_ff;  prev_wd = new_node;
                     head_in  = new_node;
                     count_in = count_ff + 1'b1;
                  end
               end
               dlle_pkg::MODE_INS_AFTER: begin
                  if (empty) status_in = dlle_pkg::STAT_EMPTY;
                  else if (full) status_in = dlle_pkg::STAT_FULL;
                  else begin
                     cur_in   = head_ff;
                     state_in = dlle_pkg::ST_FETCH;
                  end
               end
               dlle_pkg::MODE_DEL_HEAD, dlle_pkg::MODE_DEL_AFTER,
               dlle_pkg::MODE_DEL_VALUE, dlle_pkg::MODE_READ_FWD: begin
                  if (empty) status_in = dlle_pkg::STAT_EMPTY;
                  else begin
                     cur_in   = head_ff;
                     k_in     = '0;
                     state_in = dlle_pkg::ST_FETCH;
                  end
               end
               dlle_pkg::MODE_DEL_TAIL, dlle_pkg::MODE_READ_REV: begin
                  if (empty) status_in = dlle_pkg::STAT_EMPTY;
                  else begin
                     cur_in   = tail_ff;
                     k_in     = '0;
                     state_in = dlle_pkg::ST_FETCH;
                  end
               end
               default: status_in = dlle_pkg::STAT_OK;
            endcase
         end

         // memory read of cur in flight
         dlle_pkg::ST_FETCH: begin
            case (mode_ff)
               dlle_pkg::MODE_READ_FWD, dlle_pkg::MODE_READ_REV:
                  state_in = dlle_pkg::ST_RDOUT;
               dlle_pkg::MODE_DEL_HEAD, dlle_pkg::MODE_DEL_TAIL:
                  state_in = dlle_pkg::ST_DEL;
               default:
                  state_in = dlle_pkg::ST_SCHK;
            endcase
         end

         // one node checked per cycle; next read issued straight from the link
         dlle_pkg::ST_SCHK: begin
            if (match) begin
               case (mode_ff)
                  dlle_pkg::MODE_INS_AFTER: state_in = dlle_pkg::ST_INS_A;
                  dlle_pkg::MODE_DEL_AFTER: begin
                     raddr    = rn_ff;
                     cur_in   = rn_ff;
                     state_in = dlle_pkg::ST_DEL;
                  end
                  default: state_in = dlle_pkg::ST_DEL;
               endcase
            end else if (cur_ff == tail_ff) begin
               status_in = dlle_pkg::STAT_NOTFOUND;
               state_in  = dlle_pkg::ST_RESP;
            end else begin
               raddr  = rn_ff;
               cur_in = rn_ff;
            end
         end

         // new node after cur: its own entries and the tail
         dlle_pkg::ST_INS_A: begin
            alloc_req.pop = 1'b1;
            val_we  = 1'b1; val_wa  = new_node; val_wd  = value_ff;
            prev_we = 1'b1; prev_wa = new_node; prev_wd = cur_ff;
            next_we = 1'b1; next_wa = new_node; next_wd = rn_ff;
            n_in       = new_node;
            q_in       = rn_ff;
            wastail_in = cur_ff == tail_ff;
            if (cur_ff == tail_ff) tail_in = new_node;
            state_in = dlle_pkg::ST_INS_B;
         end

         // splice the neighbors onto it
         dlle_pkg::ST_INS_B: begin
            next_we = 1'b1; next_wa = cur_ff; next_wd = n_ff;
            if (!wastail_ff) begin
               prev_we = 1'b1; prev_wa = q_ff; prev_wd = n_ff;
            end
            count_in = count_ff + 1'b1;
            state_in = dlle_pkg::ST_RESP;
         end

         // unlink cur; its links are in rn/rp
         dlle_pkg::ST_DEL: begin
            if (count_ff <= CW'(1)) begin
               count_in = '0;
            end else begin
               if (cur_ff == head_ff) head_in = rn_ff;
               else if (cur_ff == tail_ff) tail_in = rp_ff;
               else begin
                  next_we = 1'b1; next_wa = rp_ff; next_wd = rn_ff;
                  prev_we = 1'b1; prev_wa = rn_ff; prev_wd = rp_ff;
               end
               count_in = count_ff - 1'b1;
            end
            alloc_req.push     = 1'b1;
            alloc_req.push_idx = cur_ff;
            state_in = dlle_pkg::ST_RESP;
         end

         dlle_pkg::ST_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = '0;
               rsp_count_in  = 6'(count_ff);
               rsp_last_in   = 1'b1;
               state_in      = dlle_pkg::ST_IDLE;
            end
         end

         // one element per transfer; stalled reads re-read cur
         dlle_pkg::ST_RDOUT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = dlle_pkg::STAT_OK;
               rsp_value_in  = rv_ff;
               rsp_count_in  = 6'(count_ff);
               rsp_last_in   = rd_last;
               if (rd_last) begin
                  state_in = dlle_pkg::ST_IDLE;
               end else begin
                  raddr  = link;
                  cur_in = link;
                  k_in   = k_ff + 1'b1;
               end
            end
         end

         default: state_in = dlle_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlle_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      q_ff          <= q_in;
      wastail_ff    <= wastail_in;
      k_ff          <= k_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (val_we)  val_mem[val_wa]   <= val_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      rv_ff <= val_mem[raddr];
      rn_ff <= next_mem[raddr];
      rp_ff <= prev_mem[raddr];
   end

endmodule

/* rtl/dlle_checker.sv */
// Port-level checks of the doubly linked list engine, bound to the top level.
module dlle_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_status,
   input logic signed [31:0] rsp_value_out,
   input logic [5:0]         rsp_count,
   input logic               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_value_out) && $stable(rsp_count) && $stable(rsp_last))
      else $error("result dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while busy");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != dlle_pkg::STAT_OK |-> rsp_last && rsp_value_out == 32'sd0)
      else $error("error result not final or carries data");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset did not clear");

endmodule

bind doubly_linked_list_engine dlle_checker u_dlle_checker (.*);

/* dv/doubly_linked_list_engine_tb.sv */
// Testbench for the doubly linked list engine: random and directed commands, scoreboard check.
`timescale 1ns / 100ps

typedef struct {
   logic [1:0]  status;
   logic [31:0] value_out;
   logic [5:0]  count;
   logic        last;
} list_rsp_type;

class list_scoreboard;
   logic [31:0]                node_val [dlle_pkg::NODES];
   logic [dlle_pkg::IDX_W-1:0] nxt [dlle_pkg::NODES];
   logic [dlle_pkg::IDX_W-1:0] prv [dlle_pkg::NODES];
   logic [dlle_pkg::IDX_W-1:0] head, tail;
   logic [dlle_pkg::NODES-1:0] free_nodes;
   int                         used;
   list_rsp_type               pending[$];
   int                         errors;

   function new();
      head = '0; tail = '0; free_nodes = '1; used = 0; errors = 0;
   endfunction

   function logic [dlle_pkg::IDX_W-1:0] grab_node();
      for (int i = 0; i < dlle_pkg::NODES; i++)
         if (free_nodes[i]) begin
            free_nodes[i] = 1'b0;
            return dlle_pkg::IDX_W'(i);
         end
      return '0;
   endfunction

   // first node equal to key, optionally skipping the tail
   function bit search(logic [31:0] key, bit skip_tail,
                       output logic [dlle_pkg::IDX_W-1:0] hit);
      logic [dlle_pkg::IDX_W-1:0] idx;
      idx = head;
      hit = '0;
      for (int k = 0; k < used; k++) begin
         if (node_val[idx] == key && !(skip_tail && idx == tail)) begin
            hit = idx;
            return 1;
         end
         if (idx == tail) return 0;
         idx = nxt[idx];
      end
      return 0;
   endfunction

   function void unlink(logic [dlle_pkg::IDX_W-1:0] i);
      if (used <= 1) used = 0;
      else begin
         if (i == head) head = nxt[i];
         else if (i == tail) tail = prv[i];
         else begin
            nxt[prv[i]] = nxt[i];
            prv[nxt[i]] = prv[i];
         end
         used--;
      end
      free_nodes[i] = 1'b1;
   endfunction

   function void push_tail(logic [31:0] v);
      logic [dlle_pkg::IDX_W-1:0] n;
      n = grab_node();
      node_val[n] = v;
      if (used == 0) head = n;
      else begin
         nxt[tail] = n;
         prv[n] = tail;
      end
      tail = n;
      used++;
   endfunction

   function void add_result(logic [1:0] st, logic [31:0] v, bit lst);
      list_rsp_type r;
      r.status = st; r.value_out = v; r.count = used[5:0]; r.last = lst;
      pending.push_back(r);
   endfunction

   // note an accepted command and queue what it must produce
   function void note_command(logic [3:0] mode, logic [31:0] value, logic [31:0] key);
      logic [1:0]                 st;
      logic [dlle_pkg::IDX_W-1:0] p, n, idx;
      bit                         full;
      int                         total;
      full = used >= dlle_pkg::NODES;
      st = dlle_pkg::STAT_OK;
      case (mode)
         dlle_pkg::MODE_APPEND: begin
            if (full) st = dlle_pkg::STAT_FULL; else push_tail(value);
         end
         dlle_pkg::MODE_INS_HEAD, dlle_pkg::MODE_INS_TAIL: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY;
            else if (full) st = dlle_pkg::STAT_FULL;
            else if (mode == dlle_pkg::MODE_INS_TAIL) push_tail(value);
            else begin
               n = grab_node();
               node_val[n] = value;
               nxt[n] = head;
               prv[head] = n;
               head = n;
               used++;
            end
         end
         dlle_pkg::MODE_INS_AFTER: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY;
            else if (full) st = dlle_pkg::STAT_FULL;
            else if (!search(key, 0, p)) st = dlle_pkg::STAT_NOTFOUND;
            else begin
               n = grab_node();
               node_val[n] = value;
               prv[n] = p;
               nxt[n] = nxt[p];
               if (p == tail) tail = n;
               else prv[nxt[p]] = n;
               nxt[p] = n;
               used++;
            end
         end
         dlle_pkg::MODE_DEL_HEAD: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY; else unlink(head);
         end
         dlle_pkg::MODE_DEL_TAIL: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY; else unlink(tail);
         end
         dlle_pkg::MODE_DEL_AFTER: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY;
            else if (!search(key, 1, p)) st = dlle_pkg::STAT_NOTFOUND;
            else unlink(nxt[p]);
         end
         dlle_pkg::MODE_DEL_VALUE: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY;
            else if (!search(key, 0, p)) st = dlle_pkg::STAT_NOTFOUND;
            else unlink(p);
         end
         dlle_pkg::MODE_READ_FWD, dlle_pkg::MODE_READ_REV: begin
            if (used == 0) st = dlle_pkg::STAT_EMPTY;
            else begin
               total = (used < dlle_pkg::MAX_RESULTS) ? used : dlle_pkg::MAX_RESULTS;
               idx = (mode == dlle_pkg::MODE_READ_FWD) ? head : tail;
               for (int k = 0; k < total; k++) begin
                  add_result(dlle_pkg::STAT_OK, node_val[idx], k + 1 == total);
                  idx = (mode == dlle_pkg::MODE_READ_FWD) ? nxt[idx] : prv[idx];
               end
               return;
            end
         end
         default: ;
      endcase
      add_result(st, '0, 1'b1);
   endfunction

   function void check_result(logic [1:0] st, logic [31:0] v, logic [5:0] c, logic lst);
      list_rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result: status %0d value %0h count %0d", st, v, c);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
         $error("status: expected %0d actual %0d", e.status, st); errors++;
      end
      if (v !== e.value_out) begin
         $error("value_out: expected %0h actual %0h", e.value_out, v); errors++;
      end
      if (c !== e.count) begin
         $error("count: expected %0d actual %0d", e.count, c); errors++;
      end
      if (lst !== e.last) begin
         $error("last: expected %0d actual %0d", e.last, lst); errors++;
      end
   endfunction
endclass

module doubly_linked_list_engine_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_mode = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_key = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_value_out;
   logic [5:0]         rsp_count;
   logic               rsp_last;

   list_scoreboard scb = new();

   // idle percentages per side; hold_off forces a long receiver stall
   int  send_idle_pct = 9;
   int  recv_idle_pct = 67;
   bit  hold_off = 1'b0;
   int  quiet_cycles = 0;

   always #2 clock = ~clock;

   doubly_linked_list_engine DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_mode(req_mode), .req_value(req_value), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_value_out(rsp_value_out),
      .rsp_count(rsp_count), .rsp_last(rsp_last)
   );

   // receiver side: check every result transfer, then pick next ready
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            scb.check_result(rsp_status, rsp_value_out, rsp_count, rsp_last);
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles with no transfer on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else if (!reset) quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one command transfer; the model is updated at the accepting edge.
   // valid stays high into the next command unless the sender idles.
   task automatic send_cmd(logic [3:0] mode, logic [31:0] value, logic [31:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      scb.note_command(mode, value, key);
   endtask

   function automatic logic [31:0] pick_val();
      case ($urandom_range(3))
         0: return $urandom_range(7);              // small set, duplicates likely
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // key: mostly a value held in the list, sometimes a likely miss
   function automatic logic [31:0] pick_key();
      if (scb.used > 0 && $urandom_range(99) < 75) begin
         logic [dlle_pkg::IDX_W-1:0] idx;
         int steps;
         idx = scb.head;
         steps = $urandom_range(scb.used - 1);
         for (int k = 0; k < steps; k++) idx = scb.nxt[idx];
         return scb.node_val[idx];
      end
      return pick_val();
   endfunction

   task automatic random_cmds(int n, int grow_pct);
      logic [3:0] mode;
      for (int i = 0; i < n; i++) begin
         // bias toward growth or shrink so fills and empties are both reached
         if ($urandom_range(99) < 4) mode = 4'(10 + $urandom_range(5));
         else if ($urandom_range(99) < grow_pct) mode = 4'($urandom_range(3));
         else mode = 4'($urandom_range(4, 9));
         send_cmd(mode, pick_val(), pick_key());
      end
   endtask

   task automatic drain();
      while (scb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty-list cases first
      send_cmd(dlle_pkg::MODE_READ_FWD,  '0, '0);
      send_cmd(dlle_pkg::MODE_INS_HEAD,  32'h1, '0);
      send_cmd(dlle_pkg::MODE_INS_TAIL,  32'h1, '0);
      send_cmd(dlle_pkg::MODE_INS_AFTER, 32'h1, 32'h1);
      send_cmd(dlle_pkg::MODE_DEL_HEAD,  '0, '0);
      send_cmd(dlle_pkg::MODE_DEL_TAIL,  '0, '0);
      send_cmd(dlle_pkg::MODE_DEL_AFTER, '0, '0);
      send_cmd(dlle_pkg::MODE_DEL_VALUE, '0, '0);
      // append to empty, then each insert kind with field extremes
      send_cmd(dlle_pkg::MODE_APPEND,    32'h8000_0000, '0);
      send_cmd(dlle_pkg::MODE_INS_HEAD,  32'h7FFF_FFFF, '0);
      send_cmd(dlle_pkg::MODE_INS_TAIL,  32'hFFFF_FFFF, '0);
      send_cmd(dlle_pkg::MODE_INS_AFTER, 32'h0000_0000, 32'h7FFF_FFFF);
      send_cmd(dlle_pkg::MODE_INS_AFTER, 32'h5, 32'h1234_5678);      // key not found
      send_cmd(dlle_pkg::MODE_READ_REV,  '0, '0);
      send_cmd(dlle_pkg::MODE_DEL_AFTER, '0, 32'hFFFF_FFFF);         // key only at tail
      send_cmd(dlle_pkg::MODE_DEL_AFTER, '0, 32'h7FFF_FFFF);
      send_cmd(dlle_pkg::MODE_DEL_VALUE, '0, 32'h7FFF_FFFF);         // match at head
      send_cmd(4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);                  // unused mode
      send_cmd(dlle_pkg::MODE_READ_FWD,  '0, '0);
      // fill the pool, then hit full on append, insert at head and insert after
      for (int i = 0; i < dlle_pkg::NODES; i++) send_cmd(dlle_pkg::MODE_APPEND, $urandom, '0);
      send_cmd(dlle_pkg::MODE_INS_HEAD,  32'h3, '0);
      send_cmd(dlle_pkg::MODE_INS_AFTER, 32'h3, scb.node_val[scb.head]);
      send_cmd(dlle_pkg::MODE_READ_FWD,  '0, '0);
      send_cmd(dlle_pkg::MODE_DEL_TAIL,  '0, '0);

      // long receiver stall while commands keep coming
      fork
         begin
            hold_off = 1'b1;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         random_cmds(20, 50);
      join

      random_cmds(100, 55);
      send_idle_pct = 67; recv_idle_pct = 9;
      random_cmds(100, 45);
      send_idle_pct = 0;  recv_idle_pct = 0;
      random_cmds(95, 50);
      req_valid <= 1'b0;

      drain();
      if (scb.errors == 0 && scb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* doubly_linked_list_engine.f */
rtl/dlle_pkg.sv
rtl/dlle_alloc.sv
rtl/doubly_linked_list_engine.sv
rtl/dlle_checker.sv
dv/doubly_linked_list_engine_tb.sv
